/* sv/css_pkg.sv */
// css_pkg: item types, sequencer states and fixed constants for the
// cosine similarity stream block. No dependencies.
`default_nettype none
package css_pkg;

   localparam int ELEM_W    = 16;
   localparam int SRCH_BITS = 14;
   localparam int CMP_SH    = 2 * SRCH_BITS;
   localparam int Q_W       = SRCH_BITS + 1;
   localparam int K_W       = $clog2(SRCH_BITS);
   localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << SRCH_BITS;

   typedef struct packed {
      logic signed [ELEM_W-1:0] a_elem;
      logic signed [ELEM_W-1:0] b_elem;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] cosine;
      logic                     degenerate;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_MUL_P,
      ST_MUL_D,
      ST_CHECK,
      ST_SRCH_A,
      ST_SRCH_B,
      ST_SRCH_C
   } state_type;

endpackage
`default_nettype wire

/* sv/cosine_similarity_stream_top.sv */
// cosine_similarity_stream_top: streaming cosine similarity, Q1.15 in, Q2.14 out.
// Depends on css_pkg (item types, states, constants).
//
//   channel | ports                    | handshake
//   req     | start, busy, req_item    | taken when start && !busy
//   rsp     | rsp_strobe, rsp_item     | one-cycle strobe, no backpressure
//
// Pairs that are not last are taken back to back, one per cycle, while busy is low.
// A last pair holds busy through one setup state, two NW-step shift-add
// multiplications on the shared adder (norm product, then dot squared), one clamp
// check, then three search states per result bit over 14 bits. A zero norm holds
// busy only for setup, a clamped result to the check. The result strobes as busy drops.
// Synchronous reset clears the sums and the sequencer.
`default_nettype none
module cosine_similarity_stream_top #(
   parameter int MAX_LEN = 1024
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  css_pkg::req_type     req_item,
   output logic                 rsp_strobe,
   output css_pkg::rsp_type     rsp_item
);

   localparam int NW    = $clog2(MAX_LEN) + 31;
   localparam int DW    = NW + 1;
   localparam int SW    = DW + 1;
   localparam int PW    = 2 * NW;
   localparam int CW    = PW + css_pkg::CMP_SH;
   localparam int CNT_W = $clog2(NW);
   localparam logic [SW-1:0] LIM = SW'(MAX_LEN) << 30;

   css_pkg::state_type state_ff, state_in;

   logic signed [DW-1:0] dot_ff, dot_in;
   logic [NW-1:0]        na_ff, na_in, nb_ff, nb_in;
   logic [PW-1:0]        mcand_ff, mcand_in;
   logic [NW-1:0]        mplier_ff, mplier_in;
   logic [NW-1:0]        dmag_ff, dmag_in;
   logic                 neg_ff, neg_in;
   logic [PW-1:0]        p_ff, p_in;
   logic [CW-1:0]        r_ff, r_in;
   logic [CW-1:0]        work_ff, work_in;
   logic [CW-1:0]        s_ff, s_in;
   logic [CW-1:0]        qk_ff, qk_in;
   logic [CW-1:0]        pk_ff, pk_in;
   logic [css_pkg::Q_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 strobe_ff, strobe_in;
   css_pkg::rsp_type     rsp_ff, rsp_in;

   logic signed [31:0]   prod_ab, prod_aa, prod_bb;
   logic signed [SW-1:0] dsum;
   logic [NW:0]          nasum, nbsum;
   logic [CW-1:0]        add_a, add_b, add_sum;
   logic                 fits;
   logic                 take;
   logic                 mul_end;

   assign take    = start && (state_ff == css_pkg::ST_IDLE);
   assign busy    = (state_ff != css_pkg::ST_IDLE);
   assign mul_end = (cnt_ff == CNT_W'(NW - 1));

   always_comb begin
      prod_ab = req_item.a_elem * req_item.b_elem;
      prod_aa = req_item.a_elem * req_item.a_elem;
      prod_bb = req_item.b_elem * req_item.b_elem;
      dsum    = SW'(dot_ff) + SW'(prod_ab);
      nasum   = {1'b0, na_ff} + (NW + 1)'(prod_aa[30:0]);
      nbsum   = {1'b0, nb_ff} + (NW + 1)'(prod_bb[30:0]);
   end

   // shared adder
   always_comb begin
      add_a = work_ff;
      add_b = '0;
      unique case (state_ff)
         css_pkg::ST_MUL_P, css_pkg::ST_MUL_D: begin
            add_a = work_ff;
            add_b = mplier_ff[0] ? CW'(mcand_ff) : '0;
         end
         css_pkg::ST_SRCH_A: begin
            add_a = s_ff;
            add_b = qk_ff;
         end
         css_pkg::ST_SRCH_B: begin
            add_a = work_ff;
            add_b = pk_ff;
         end
         css_pkg::ST_SRCH_C: begin
            add_a = qk_ff >> 1;
            add_b = fits ? pk_ff : '0;
         end
         default: begin
            add_a = work_ff;
            add_b = '0;
         end
      endcase
      add_sum = add_a + add_b;
   end

   assign fits = (work_ff <= r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= css_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
         dot_ff    <= '0;
         na_ff     <= '0;
         nb_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         dot_ff    <= dot_in;
         na_ff     <= na_in;
         nb_ff     <= nb_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      dmag_ff   <= dmag_in;
      neg_ff    <= neg_in;
      p_ff      <= p_in;
      r_ff      <= r_in;
      work_ff   <= work_in;
      s_ff      <= s_in;
      qk_ff     <= qk_in;
      pk_ff     <= pk_in;
      q_ff      <= q_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      dot_in    = dot_ff;
      na_in     = na_ff;
      nb_in     = nb_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      dmag_in   = dmag_ff;
      neg_in    = neg_ff;
      p_in      = p_ff;
      r_in      = r_ff;
      work_in   = work_ff;
      s_in      = s_ff;
      qk_in     = qk_ff;
      pk_in     = pk_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      rsp_in    = rsp_ff;

      unique case (state_ff)
         css_pkg::ST_IDLE: begin
            if (take) begin
               if (dsum > $signed(LIM)) begin
                  dot_in = DW'($signed(LIM));
               end else if (dsum < -$signed(LIM)) begin
                  dot_in = DW'(-$signed(LIM));
               end else begin
                  dot_in = DW'(dsum);
               end
               na_in = (nasum > (NW + 1)'(LIM)) ? NW'(LIM) : NW'(nasum);
               nb_in = (nbsum > (NW + 1)'(LIM)) ? NW'(LIM) : NW'(nbsum);
               if (req_item.last) begin
                  state_in = css_pkg::ST_START;
               end
            end
         end
         css_pkg::ST_START: begin
            neg_in    = dot_ff[DW-1];
            dmag_in   = dot_ff[DW-1] ? NW'(-dot_ff) : NW'(dot_ff);
            mcand_in  = PW'(na_ff);
            mplier_in = nb_ff;
            work_in   = '0;
            cnt_in    = '0;
            dot_in    = '0;
            na_in     = '0;
            nb_in     = '0;
            if (na_ff == '0 || nb_ff == '0) begin
               rsp_in.cosine     = '0;
               rsp_in.degenerate = 1'b1;
               strobe_in         = 1'b1;
               state_in          = css_pkg::ST_IDLE;
            end else begin
               state_in = css_pkg::ST_MUL_P;
            end
         end
         css_pkg::ST_MUL_P: begin
            work_in   = add_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (mul_end) begin
               p_in      = add_sum[PW-1:0];
               mcand_in  = PW'(dmag_ff);
               mplier_in = dmag_ff;
               work_in   = '0;
               cnt_in    = '0;
               state_in  = css_pkg::ST_MUL_D;
            end
         end
         css_pkg::ST_MUL_D: begin
            work_in   = add_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (mul_end) begin
               r_in     = {add_sum[PW-1:0], {css_pkg::CMP_SH{1'b0}}};
               state_in = css_pkg::ST_CHECK;
            end
         end
         css_pkg::ST_CHECK: begin
            if ({p_ff, {css_pkg::CMP_SH{1'b0}}} <= r_ff) begin
               rsp_in.cosine     = neg_ff ? -css_pkg::ELEM_W'(css_pkg::Q_ONE)
                                          : css_pkg::ELEM_W'(css_pkg::Q_ONE);
               rsp_in.degenerate = 1'b0;
               strobe_in         = 1'b1;
               state_in          = css_pkg::ST_IDLE;
            end else begin
               s_in     = '0;
               qk_in    = '0;
               pk_in    = CW'({p_ff, {(css_pkg::CMP_SH - 2){1'b0}}});
               q_in     = '0;
               cnt_in   = CNT_W'(css_pkg::SRCH_BITS - 1);
               state_in = css_pkg::ST_SRCH_A;
            end
         end
         css_pkg::ST_SRCH_A: begin
            work_in  = add_sum;
            state_in = css_pkg::ST_SRCH_B;
         end
         css_pkg::ST_SRCH_B: begin
            work_in  = add_sum;
            state_in = css_pkg::ST_SRCH_C;
         end
         css_pkg::ST_SRCH_C: begin
            qk_in = add_sum;
            pk_in = pk_ff >> 2;
            if (fits) begin
               s_in = work_ff;
               q_in[cnt_ff[css_pkg::K_W-1:0]] = 1'b1;
            end
            if (cnt_ff == '0) begin
               rsp_in.cosine     = neg_ff ? -css_pkg::ELEM_W'(q_in)
                                          : css_pkg::ELEM_W'(q_in);
               rsp_in.degenerate = 1'b0;
               strobe_in         = 1'b1;
               state_in          = css_pkg::ST_IDLE;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = css_pkg::ST_SRCH_A;
            end
         end
         default: begin
            state_in = css_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
`default_nettype wire

/* sv/css_checker.sv */
// css_checker: port-level checks for cosine_similarity_stream_top, bound below.
// Depends on css_pkg (item types).
`default_nettype none
module css_checker (
   input wire              clock,
   input wire              reset,
   input wire              start,
   input wire              busy,
   input css_pkg::req_type req_item,
   input wire              rsp_strobe,
   input css_pkg::rsp_type rsp_item
);

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.last |=> busy)
      else $error("last item did not start the final computation");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.degenerate |-> rsp_item.cosine == '0)
      else $error("degenerate result with nonzero cosine");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.cosine <= 16384) && (rsp_item.cosine >= -16384))
      else $error("cosine out of range");

endmodule

bind cosine_similarity_stream_top css_checker u_css_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
`default_nettype wire
